[sv/pcbre_pkg.sv]
// Shared types and constants for the pseudo beta-carbon restraint energy block.
// No dependencies; imported by pcbre_root, the top level and the bench.
`default_nettype none

package pcbre_pkg;

    // Coordinates and targets: signed Q15.8
    typedef logic signed [23:0] coord_t;

    localparam int unsigned BOND_W = 11;
    localparam int unsigned TERM_W = 26;
    localparam int unsigned TOTAL_W = 38;
    // Radicand (sum of three squares of 27-bit values) and rounded root widths
    localparam int unsigned RAD_W = 52;
    localparam int unsigned ROOT_W = 27;

    localparam logic [BOND_W-1:0] IDEAL_BOND_RESET = 11'd391;
    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef logic [BOND_W-1:0] bond_t;
    typedef logic [TERM_W-1:0] term_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [RAD_W-1:0] rad_t;
    typedef logic [ROOT_W-1:0] root_t;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_VEC   = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_ROOT  = 9'b000001000,
        S_MULB  = 9'b000010000,
        S_DLOAD = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_DIFF  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

[sv/pcbre_root.sv]
// Iterative rounded square root: two radicand bits per cycle, ties rounded up.
// Depends on pcbre_pkg for the radicand and root widths.
`default_nettype none

module pcbre_root (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire pcbre_pkg::rad_t radicand,
    output logic                done,
    output pcbre_pkg::root_t    root
);
    import pcbre_pkg::*;

    rad_t rem_reg, rem_next;
    rad_t r_reg, r_next;
    rad_t bit_reg, bit_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [RAD_W:0] trial;

    // Trial subtrahend of this step
    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    // Advance one digit pair per cycle
    always_comb begin
        rem_next  = rem_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            r_next    = '0;
            bit_next  = rad_t'(1) << (RAD_W - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[RAD_W-1:0];
                r_next   = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    // Round: the remainder exceeds the root when the fraction is at least one half
    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0] + ROOT_W'(rem_reg > r_reg);

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("root done while still iterating");
    a_busy_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start) |=> (busy_reg || done_reg))
        else $error("root iteration stopped without done");
    a_final_root_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (r_reg >> ROOT_W) == '0)
        else $error("root wider than its result");
`endif

endmodule

`default_nettype wire

[sv/pseudo_cb_restraint_energy.sv]
// Pseudo beta-carbon restraint energy: one result per alpha-carbon transaction.
// Unscored residue: no term; the transaction goes straight to S_FIN and back to S_IDLE for the next one.
// Scored residue: the result is set by the shared 28x28 multiplier, the 26-step square root
// (run twice) and the 12-step divider per axis, bond multiply and divider skipped with a zero
// sum vector; the next transaction is taken while the result waits; a stalled result holds it.
// Synchronous active-low reset clears the chain state, the total and the bond to 391.
`default_nettype none

module pseudo_cb_restraint_energy (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire pcbre_pkg::bond_t  cfg_ideal_bond,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pcbre_pkg::coord_t s_ca_x,
    input  wire pcbre_pkg::coord_t s_ca_y,
    input  wire pcbre_pkg::coord_t s_ca_z,
    input  wire logic              s_has_target,
    input  wire pcbre_pkg::coord_t s_target_x,
    input  wire pcbre_pkg::coord_t s_target_y,
    input  wire pcbre_pkg::coord_t s_target_z,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_term_valid,
    output pcbre_pkg::term_t       m_term,
    output pcbre_pkg::total_t      m_total,
    output logic                   m_done_res
);
    import pcbre_pkg::*;

    // Control and chain state
    state_t state_reg, state_next;
    logic phase_reg, phase_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] cnt_reg, cnt_next;
    bond_t bond_reg, bond_next;
    coord_t win0_reg [3], win0_next [3];
    coord_t win1_reg [3], win1_next [3];
    coord_t pt_reg [3], pt_next [3];
    logic pflag_reg, pflag_next;
    logic [1:0] seen_reg, seen_next;
    total_t total_reg, total_next;
    logic m_valid_reg, m_valid_next;

    // Working registers
    coord_t ca_reg [3], ca_next [3];
    coord_t tin_reg [3], tin_next [3];
    logic hast_reg, hast_next;
    logic last_reg, last_next;
    logic signed [26:0] vec_reg [3], vec_next [3];
    rad_t prod_reg, prod_next;
    rad_t acc_reg, acc_next;
    logic zero_reg, zero_next;
    root_t n_reg, n_next;
    logic [39:0] num_reg, num_next;
    logic [39:0] dsh_reg, dsh_next;
    logic [11:0] q_reg, q_next;
    logic signed [12:0] off_reg [3], off_next [3];
    term_t term_reg, term_next;
    logic tval_reg, tval_next;
    logic m_term_valid_reg, m_term_valid_next;
    term_t m_term_reg, m_term_next;
    total_t m_total_reg, m_total_next;
    logic m_done_reg, m_done_next;

    // Shared unit and helpers
    logic signed [27:0] mul_a, mul_b;
    logic signed [55:0] mul_p;
    logic [1:0] sq_idx;
    logic [26:0] mag;
    logic ge;
    logic [11:0] q_fin;
    logic [38:0] tsum;
    logic root_start, root_done;
    root_t root_val;
    logic signed [24:0] pseudo;
    logic s_fire, out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign sq_idx = (cnt_reg[1:0] == 2'd3) ? 2'd0 : cnt_reg[1:0];
    assign mag = vec_reg[axis_reg][26] ? 27'(-vec_reg[axis_reg]) : 27'(vec_reg[axis_reg]);
    assign ge = num_reg >= dsh_reg;
    assign q_fin = {q_reg[10:0], ge};
    assign tsum = {1'b0, total_reg} + 39'(term_reg);

    // Shared multiplier: squares, or bond times axis magnitude
    always_comb begin
        if (state_reg == S_MULB) begin
            mul_a = 28'(bond_reg);
            mul_b = {1'b0, mag};
        end else begin
            mul_a = 28'(vec_reg[sq_idx]);
            mul_b = 28'(vec_reg[sq_idx]);
        end
    end
    assign mul_p = mul_a * mul_b;

    pcbre_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_next),
        .done     (root_done),
        .root     (root_val)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        bond_next  = bond_reg;
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        pt_next    = pt_reg;
        pflag_next = pflag_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ca_next    = ca_reg;
        tin_next   = tin_reg;
        hast_next  = hast_reg;
        last_next  = last_reg;
        vec_next   = vec_reg;
        prod_next  = mul_p[RAD_W-1:0];
        acc_next   = acc_reg;
        zero_next  = zero_reg;
        n_next     = n_reg;
        num_next   = num_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        off_next   = off_reg;
        term_next  = term_reg;
        tval_next  = tval_reg;
        m_term_valid_next = m_term_valid_reg;
        m_term_next  = m_term_reg;
        m_total_next = m_total_reg;
        m_done_next  = m_done_reg;
        root_start = 1'b0;
        pseudo     = '0;

        // Take a register write
        if (cfg_valid) begin
            bond_next = cfg_ideal_bond;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    ca_next  = '{s_ca_x, s_ca_y, s_ca_z};
                    tin_next = '{s_target_x, s_target_y, s_target_z};
                    hast_next = s_has_target;
                    last_next = s_last;
                    if (seen_reg == 2'd2 && pflag_reg) begin
                        state_next = S_VEC;
                    end else begin
                        term_next  = '0;
                        tval_next  = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_VEC: begin
                // Sum vector (CA - CAprev) + (CA - CAnext)
                for (int i = 0; i < 3; i++) begin
                    vec_next[i] = 27'(win1_reg[i]) + 27'(win1_reg[i])
                                - 27'(win0_reg[i]) - 27'(ca_reg[i]);
                end
                phase_next = 1'b0;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                // Accumulate three squares, one behind the multiplier
                if (cnt_reg == 4'd0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + prod_reg;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3) begin
                    root_start = 1'b1;
                    zero_next  = (acc_next == '0);
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    if (!phase_reg) begin
                        n_next = root_val;
                        if (zero_reg) begin
                            off_next   = '{3{13'sd0}};
                            state_next = S_DIFF;
                        end else begin
                            axis_next  = '0;
                            state_next = S_MULB;
                        end
                    end else begin
                        term_next  = (root_val > ROOT_W'(TERM_MAX)) ? TERM_MAX
                                                                   : root_val[TERM_W-1:0];
                        tval_next  = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_MULB: begin
                state_next = S_DLOAD;
            end
            S_DLOAD: begin
                // Rounded quotient: (2*bond*|s| + n) / (2*n)
                num_next   = {prod_reg[38:0], 1'b0} + 40'(n_reg);
                dsh_next   = 40'({n_reg, 1'b0}) << 11;
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (ge) begin
                    num_next = num_reg - dsh_reg;
                end
                q_next   = q_fin;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd11) begin
                    off_next[axis_reg] = vec_reg[axis_reg][26] ? -13'(q_fin) : 13'(q_fin);
                    if (axis_reg == 2'd2) begin
                        state_next = S_DIFF;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_MULB;
                    end
                end
            end
            S_DIFF: begin
                // Target minus pseudo position
                for (int i = 0; i < 3; i++) begin
                    pseudo      = 25'(win1_reg[i]) + 25'(off_reg[i]);
                    vec_next[i] = 27'(pt_reg[i]) - 27'(pseudo);
                end
                phase_next = 1'b1;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_term_valid_next = tval_reg;
                    m_term_next       = term_reg;
                    m_total_next      = tsum[38] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
                    m_done_next       = last_reg;
                    if (last_reg) begin
                        win0_next  = '{3{24'sd0}};
                        win1_next  = '{3{24'sd0}};
                        pt_next    = '{3{24'sd0}};
                        pflag_next = 1'b0;
                        seen_next  = '0;
                        total_next = '0;
                    end else begin
                        win0_next  = win1_reg;
                        win1_next  = ca_reg;
                        pt_next    = tin_reg;
                        pflag_next = hast_reg;
                        total_next = m_total_next;
                        if (seen_reg != 2'd2) begin
                            seen_next = seen_reg + 2'd1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= 1'b0;
            axis_reg    <= '0;
            cnt_reg     <= '0;
            bond_reg    <= IDEAL_BOND_RESET;
            win0_reg    <= '{3{24'sd0}};
            win1_reg    <= '{3{24'sd0}};
            pt_reg      <= '{3{24'sd0}};
            pflag_reg   <= 1'b0;
            seen_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            bond_reg    <= bond_next;
            win0_reg    <= win0_next;
            win1_reg    <= win1_next;
            pt_reg      <= pt_next;
            pflag_reg   <= pflag_next;
            seen_reg    <= seen_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ca_reg   <= ca_next;
        tin_reg  <= tin_next;
        hast_reg <= hast_next;
        last_reg <= last_next;
        vec_reg  <= vec_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
        n_reg    <= n_next;
        num_reg  <= num_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        off_reg  <= off_next;
        term_reg <= term_next;
        tval_reg <= tval_next;
        m_term_valid_reg <= m_term_valid_next;
        m_term_reg  <= m_term_next;
        m_total_reg <= m_total_next;
        m_done_reg  <= m_done_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_term_valid = m_term_valid_reg;
    assign m_term       = m_term_reg;
    assign m_total      = m_total_reg;
    assign m_done_res   = m_done_reg;

`ifndef SYNTHESIS
    a_root_done_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> (state_reg == S_ROOT))
        else $error("root result outside the root wait state");
    a_unscored_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !(seen_reg == 2'd2 && pflag_reg)) |=> (state_reg == S_FIN))
        else $error("unscored transaction did not go straight to the result");
    a_no_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_term_valid_reg || m_term_reg == '0))
        else $error("term without term_valid");
    a_chain_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free && last_reg) |=>
            (total_reg == '0 && seen_reg == '0 && !pflag_reg))
        else $error("chain state not cleared after the last residue");
`endif

endmodule

`default_nettype wire

[bench/pseudo_cb_restraint_energy_tb.sv]
// Self-checking bench for pseudo_cb_restraint_energy: directed chains, then random chains.
// Depends on pcbre_pkg and the top level; predicts every result with a bit-exact model.
`timescale 1ns / 100ps

module pseudo_cb_restraint_energy_tb;
    import pcbre_pkg::*;

    typedef struct {
        coord_t cx, cy, cz;
        logic   has_t;
        coord_t tx, ty, tz;
        logic   last;
    } residue_t;

    typedef struct {
        logic   tv;
        term_t  term;
        total_t total;
        logic   done;
    } energy_t;

    // Directed row: a residue plus an optional typed-in expectation
    typedef struct {
        residue_t r;
        logic     fixed;
        energy_t  e;
    } row_t;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    bond_t cfg_ideal_bond = '0;
    logic s_valid = 1'b0, s_ready;
    coord_t s_ca_x = '0, s_ca_y = '0, s_ca_z = '0;
    coord_t s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic s_has_target = 1'b0, s_last = 1'b0;
    logic m_valid, m_ready = 1'b0, m_term_valid, m_done_res;
    term_t m_term;
    total_t m_total;

    pseudo_cb_restraint_energy DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_ideal_bond(cfg_ideal_bond),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ca_x(s_ca_x), .s_ca_y(s_ca_y), .s_ca_z(s_ca_z), .s_has_target(s_has_target),
        .s_target_x(s_target_x), .s_target_y(s_target_y), .s_target_z(s_target_z),
        .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_term_valid(m_term_valid),
        .m_term(m_term), .m_total(m_total), .m_done_res(m_done_res)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state
    longint unsigned bond_len;
    longint win_x[2], win_y[2], win_z[2];
    longint pend_x, pend_y, pend_z;
    bit pend_flag;
    int seen;
    longint unsigned energy_sum;

    energy_t expected_energy[$];
    int fails = 0, n_sent = 0, n_checked = 0, n_terms = 0, n_chains = 0;
    int send_idle = 0, recv_stall = 0;
    int quiet = 0;

    function automatic longint unsigned round_root(longint unsigned v);
        longint unsigned rem, r, b;
        begin
            rem = v; r = 0; b = 64'd1 << 62;
            while (b > rem) b >>= 2;
            while (b != 0) begin
                if (rem >= r + b) begin
                    rem -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (v - r * r > r) r++;
            return r;
        end
    endfunction

    function automatic longint bond_offset(longint s, longint unsigned n);
        longint unsigned mag, q;
        begin
            mag = (s < 0) ? -s : s;
            q = (2 * bond_len * mag + n) / (2 * n);
            return (s < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void clear_chain();
        for (int i = 0; i < 2; i++) begin
            win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
        end
        pend_x = 0; pend_y = 0; pend_z = 0;
        pend_flag = 0; seen = 0; energy_sum = 0;
    endfunction

    function automatic energy_t score_residue(residue_t r);
        energy_t e;
        longint sx, sy, sz, px, py, pz, dx, dy, dz;
        longint unsigned sq, n, t;
        begin
            e.tv = 0; t = 0;
            if (seen >= 2 && pend_flag) begin
                sx = 2 * win_x[1] - win_x[0] - longint'(r.cx);
                sy = 2 * win_y[1] - win_y[0] - longint'(r.cy);
                sz = 2 * win_z[1] - win_z[0] - longint'(r.cz);
                sq = sx * sx + sy * sy + sz * sz;
                px = win_x[1]; py = win_y[1]; pz = win_z[1];
                // Zero sum vector leaves the pseudo position on CA
                if (sq != 0) begin
                    n = round_root(sq);
                    px += bond_offset(sx, n);
                    py += bond_offset(sy, n);
                    pz += bond_offset(sz, n);
                end
                dx = pend_x - px; dy = pend_y - py; dz = pend_z - pz;
                t = round_root(dx * dx + dy * dy + dz * dz);
                if (t > TERM_MAX) t = TERM_MAX;
                e.tv = 1;
                energy_sum += t;
                if (energy_sum > TOTAL_MAX) energy_sum = TOTAL_MAX;
            end
            e.term = t;
            e.total = energy_sum;
            e.done = r.last;
            if (r.last) begin
                clear_chain();
            end else begin
                win_x[0] = win_x[1]; win_y[0] = win_y[1]; win_z[0] = win_z[1];
                win_x[1] = r.cx; win_y[1] = r.cy; win_z[1] = r.cz;
                pend_flag = r.has_t;
                pend_x = r.tx; pend_y = r.ty; pend_z = r.tz;
                if (seen < 2) seen++;
            end
            return e;
        end
    endfunction

    // Idle pacing: percentage chances for sender gap and receiver stall
    function automatic bit chance(int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // Drive one residue transaction, wait for acceptance; valid drops only while idling
    task automatic send_residue(residue_t r);
        while (chance(send_idle)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ca_x <= r.cx; s_ca_y <= r.cy; s_ca_z <= r.cz;
        s_has_target <= r.has_t;
        s_target_x <= r.tx; s_target_y <= r.ty; s_target_z <= r.tz;
        s_last <= r.last;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic write_bond(bond_t b);
        s_valid <= 1'b0;
        wait (expected_energy.size() == 0);
        repeat (150) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_ideal_bond <= b;
        do @(posedge aclk); while (!cfg_ready);
        bond_len = b;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            energy_t e;
            if (expected_energy.size() == 0) begin
                $display("%0t: unexpected result term=%0d total=%0d", $time, m_term, m_total);
                fails++;
            end else begin
                e = expected_energy.pop_front();
                n_checked++;
                if (m_term_valid !== e.tv || m_term !== e.term || m_total !== e.total ||
                    m_done_res !== e.done) begin
                    $display("%0t: mismatch expected tv=%0b term=%0d total=%0d done=%0b",
                             $time, e.tv, e.term, e.total, e.done);
                    $display("%0t:           actual tv=%0b term=%0d total=%0d done=%0b",
                             $time, m_term_valid, m_term, m_total, m_done_res);
                    fails++;
                end
            end
        end
    end

    // Receiver stalls at random
    always @(negedge aclk) m_ready <= !chance(recv_stall);

    // Watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("watchdog expired at %0t", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(3))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(4095)) - 24'sd2048;
            2: return ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
            default: return coord_t'($urandom_range(65535)) - 24'sd32768;
        endcase
    endfunction

    function automatic residue_t rand_residue(bit last);
        residue_t r;
        r.cx = rand_coord(); r.cy = rand_coord(); r.cz = rand_coord();
        r.has_t = chance(70);
        r.tx = rand_coord(); r.ty = rand_coord(); r.tz = rand_coord();
        r.last = last;
        return r;
    endfunction

    task automatic run_residue(residue_t r, bit fixed, energy_t fe);
        energy_t e;
        energy_t want;
        e = score_residue(r);
        if (e.tv) n_terms++;
        if (r.last) n_chains++;
        if (fixed && (fe.tv !== e.tv || fe.term !== e.term || fe.total !== e.total)) begin
            $display("%0t: directed row disagrees with prediction", $time);
            fails++;
        end
        want = fixed ? fe : e;
        expected_energy = {expected_energy, want};
        send_residue(r);
    endtask

    localparam coord_t PMAX = 24'sh7fffff;
    localparam coord_t NMAX = 24'sh800000;

    row_t rows[$];
    energy_t none_e = '{0, 0, 0, 0};

    // Append one directed row to the table
    task automatic add_row(residue_t r, bit fixed, energy_t e);
        row_t w;
        w.r = r;
        w.fixed = fixed;
        w.e = e;
        rows = {rows, w};
    endtask

    initial begin
        residue_t r;
        int len;
        bond_len = IDEAL_BOND_RESET;
        clear_chain();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: single residue, zero sum vector, extremes, chain end
        add_row('{0, 0, 0, 1, 100, 100, 100, 1}, 1, '{0, 0, 0, 1});
        // straight line: zero sum vector, target 256 from CA -> term 256
        add_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0});
        add_row('{256, 0, 0, 1, 256, 256, 0, 0}, 1, '{0, 0, 0, 0});
        add_row('{512, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 256, 256, 0});
        add_row('{768, 0, 0, 1, 0, 0, 0, 1}, 1, '{0, 0, 256, 1});
        // bent chain, checked by predictor
        add_row('{0, 0, 0, 1, 5, 5, 5, 0}, 0, none_e);
        add_row('{1000, 200, -300, 1, 1500, -700, 40, 0}, 0, none_e);
        add_row('{1800, -900, 50, 1, 2100, 300, 900, 0}, 0, none_e);
        add_row('{2500, 100, 700, 0, 0, 0, 0, 1}, 0, none_e);
        // coordinate extremes
        add_row('{PMAX, PMAX, PMAX, 1, NMAX, NMAX, NMAX, 0}, 0, none_e);
        add_row('{NMAX, NMAX, NMAX, 1, PMAX, PMAX, PMAX, 0}, 0, none_e);
        add_row('{PMAX, NMAX, PMAX, 1, NMAX, PMAX, NMAX, 0}, 0, none_e);
        add_row('{NMAX, PMAX, NMAX, 1, PMAX, NMAX, PMAX, 0}, 0, none_e);
        add_row('{PMAX, PMAX, NMAX, 1, -1, -1, -1, 0}, 0, none_e);
        add_row('{-1, -1, -1, 1, 0, 0, 0, 1}, 0, none_e);

        foreach (rows[i]) run_residue(rows[i].r, rows[i].fixed, rows[i].e);

        // Random chains across bond settings and idle phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            case (ph)
                0: write_bond(11'd0);
                1: write_bond(11'd2047);
                2: write_bond(11'd391);
                default: write_bond(bond_t'($urandom));
            endcase
            for (int k = 0; k < 75; ) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
                for (int j = 0; j < len; j++) begin
                    r = rand_residue(j == len - 1);
                    run_residue(r, 0, none_e);
                end
                k += len;
            end
        end

        s_valid <= 1'b0;
        send_idle = 0; recv_stall = 0;
        wait (expected_energy.size() == 0);
        repeat (150) @(posedge aclk);
        $display("sent %0d residues in %0d chains, %0d results checked, %0d terms",
                 n_sent, n_chains, n_checked, n_terms);
        $display("bond settings 0, 2047, 391 and random; four idling patterns");
        if (fails == 0 && expected_energy.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[pseudo_cb_restraint_energy.f]
sv/pcbre_pkg.sv
sv/pcbre_root.sv
sv/pseudo_cb_restraint_energy.sv
bench/pseudo_cb_restraint_energy_tb.sv
